// ===== hw/rtl/i86dec_pkg.sv =====
// Shared types, codes and opcode classification for the 8086 instruction decoder.
package i86dec_pkg;

    localparam int unsigned IN_W  = 8;
    localparam int unsigned REC_W = 57;
    localparam int unsigned OUT_W = 64;
    localparam int unsigned PAD_W = OUT_W - REC_W;

    // Record kinds
    localparam logic [3:0] K_MOV_RM     = 4'd0;
    localparam logic [3:0] K_MOV_IMM_R  = 4'd1;
    localparam logic [3:0] K_MOV_IMM_RM = 4'd2;
    localparam logic [3:0] K_MEM_ACC    = 4'd3;
    localparam logic [3:0] K_ACC_MEM    = 4'd4;
    localparam logic [3:0] K_ARI_RM     = 4'd5;
    localparam logic [3:0] K_ARI_IMM_RM = 4'd6;
    localparam logic [3:0] K_ARI_IMM_A  = 4'd7;
    localparam logic [3:0] K_JUMP       = 4'd8;
    localparam logic [3:0] K_ERROR      = 4'd9;

    // Arithmetic operations
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_CMP = 2'd2;
    localparam logic [1:0] OP_UNK = 2'd3;

    // Group field values in bits 5:3
    localparam logic [2:0] GRP_ADD = 3'b000;
    localparam logic [2:0] GRP_SUB = 3'b101;
    localparam logic [2:0] GRP_CMP = 3'b111;

    typedef enum logic [5:0] {
        PH_OPCODE  = 6'b000001,
        PH_MODRM   = 6'b000010,
        PH_DISP_LO = 6'b000100,
        PH_DISP_HI = 6'b001000,
        PH_DATA_LO = 6'b010000,
        PH_DATA_HI = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [15:0] data;
        logic [15:0] displacement;
        logic [2:0]  rm_field;
        logic [1:0]  mode;
        logic [2:0]  reg_field;
        logic        sign_extend;
        logic        wide;
        logic        to_register;
        logic [1:0]  operation;
        logic [3:0]  kind;
    } t_rec;

    typedef struct packed {
        logic halted;
        logic at_opcode;
    } t_status;

    function automatic logic [3:0] classify(input logic [7:0] b);
        logic [3:0] k;
        if (b[7:2] == 6'b100010)                   k = K_MOV_RM;
        else if (b[7:4] == 4'b1011)                k = K_MOV_IMM_R;
        else if (b[7:1] == 7'b1100011)             k = K_MOV_IMM_RM;
        else if (b[7:2] == 6'b101000)              k = b[1] ? K_ACC_MEM : K_MEM_ACC;
        else if (b[7:6] == 2'b00 && !b[2])         k = K_ARI_RM;
        else if (b[7:2] == 6'b100000)              k = K_ARI_IMM_RM;
        else if (b[7:6] == 2'b00 && b[2:1] == 2'b10) k = K_ARI_IMM_A;
        else if (b[7:4] == 4'b0111 || b[7:2] == 6'b111000) k = K_JUMP;
        else                                       k = K_ERROR;
        return k;
    endfunction

    function automatic logic [1:0] op_code(input logic [2:0] grp);
        logic [1:0] o;
        case (grp)
            GRP_ADD: o = OP_ADD;
            GRP_SUB: o = OP_SUB;
            GRP_CMP: o = OP_CMP;
            default: o = OP_UNK;
        endcase
        return o;
    endfunction

    function automatic logic has_modrm(input logic [3:0] k);
        return k == K_MOV_RM || k == K_MOV_IMM_RM || k == K_ARI_RM || k == K_ARI_IMM_RM;
    endfunction

endpackage

// ===== hw/rtl/i8086_instruction_decoder_unit.sv =====
// Top level of the 8086 instruction decoder: input register, decoder core, result register.
//
//  channel  | dir | tdata fields (lsb first)
//  ---------+-----+---------------------------------------------------------------
//  s_axis   | in  | code_byte[7:0]
//  m_axis   | out | kind[3:0] operation[5:4] to_register[6] wide[7] sign_extend[8]
//           |     | reg_field[11:9] mode[13:12] rm_field[16:14] displacement[32:17]
//           |     | data[48:33] opcode[56:49], zero pad [63:57]
//
// One code byte per cycle while no waiting result holds the decoder; the last byte of
// an instruction passes the input register, then the decoder core into the result register.
// Reset is synchronous, active low, and returns the decoder to the opcode phase.
// A waiting result holds the decoder, and with it the input once the input
// register is full; an empty input register still takes one request.
// After an unknown opcode the error record is sent and later bytes are taken
// and dropped until reset.
module i8086_instruction_decoder_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [i86dec_pkg::IN_W-1:0]      s_axis_tdata,  // code_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [i86dec_pkg::OUT_W-1:0]     m_axis_tdata   // see table above
);
    import i86dec_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_rec        r_out_rec;

    logic        out_free;
    logic        step;
    logic        in_fire;
    logic        emit;
    t_rec        rec;
    t_status     status;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    i86dec_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_emit   (emit),
        .o_rec    (rec),
        .o_status (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire)   r_in_valid <= 1'b1;
            else if (step) r_in_valid <= 1'b0;
            if (emit)               r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) r_in_byte <= s_axis_tdata;
        if (emit)    r_out_rec <= rec;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_rec};

    // a record always closes an instruction
    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> status.at_opcode)
        else $error("decoder not back at opcode phase after a record");

    // an error record halts the decoder
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && rec.kind == K_ERROR) |=> status.halted)
        else $error("error record did not halt the decoder");

    // nothing leaves once halted
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.halted |-> !emit)
        else $error("record produced while halted");

    // a held input byte is not lost while the core waits
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("pending input byte dropped");

endmodule

// ===== hw/rtl/i86dec_core.sv =====
// Decoder state, per-byte phase update and record assembly.
module i86dec_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [7:0]              i_byte,
    output logic                    o_emit,
    output i86dec_pkg::t_rec        o_rec,
    output i86dec_pkg::t_status     o_status
);
    import i86dec_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_opc, n_opc;
    logic [7:0]  r_modrm, n_modrm;
    logic [15:0] r_disp, n_disp;
    logic [15:0] r_data, n_data;
    logic        r_halted, n_halted;

    logic [3:0]  kind;
    logic        mrm;
    logic [1:0]  dlen;
    logic [1:0]  ilen;
    t_phase      nxt;
    t_rec        rec;

    always_comb begin
        n_opc   = r_opc;
        n_modrm = r_modrm;
        n_disp  = r_disp;
        n_data  = r_data;
        if (r_phase == PH_OPCODE) begin
            n_opc   = i_byte;
            n_modrm = '0;
            n_disp  = '0;
            n_data  = '0;
        end
        kind = classify(n_opc);
        mrm  = has_modrm(kind);

        // modrm-dependent lengths use the modrm byte as of this step
        if (r_phase == PH_MODRM) n_modrm = i_byte;

        if (kind == K_JUMP)                                 dlen = 2'd1;
        else if (!mrm)                                      dlen = 2'd0;
        else if (n_modrm[7:6] == 2'b01)                     dlen = 2'd1;
        else if (n_modrm[7:6] == 2'b10)                     dlen = 2'd2;
        else if (n_modrm[7:6] == 2'b00 && n_modrm[2:0] == 3'b110) dlen = 2'd2;
        else                                                dlen = 2'd0;

        case (kind)
            K_MOV_IMM_R:               ilen = n_opc[3] ? 2'd2 : 2'd1;
            K_MOV_IMM_RM, K_ARI_IMM_A: ilen = n_opc[0] ? 2'd2 : 2'd1;
            K_MEM_ACC, K_ACC_MEM:      ilen = 2'd2;
            K_ARI_IMM_RM:              ilen = (n_opc[1] || !n_opc[0]) ? 2'd1 : 2'd2;
            default:                   ilen = 2'd0;
        endcase

        case (r_phase)
            PH_DISP_LO: begin
                n_disp = {8'h00, i_byte};
                if (dlen == 2'd1 && i_byte[7]) n_disp[15:8] = 8'hFF;
            end
            PH_DISP_HI: n_disp = {i_byte, r_disp[7:0]};
            PH_DATA_LO: begin
                n_data = {8'h00, i_byte};
                if (kind == K_ARI_IMM_RM && ilen == 2'd1 && n_opc[1:0] == 2'b11 && i_byte[7])
                    n_data[15:8] = 8'hFF;
            end
            PH_DATA_HI: n_data = {i_byte, r_data[7:0]};
            default: ;
        endcase

        // advance to the next byte this instruction still needs
        case (r_phase)
            PH_OPCODE: begin
                if (kind == K_ERROR)     nxt = PH_OPCODE;
                else if (mrm)            nxt = PH_MODRM;
                else if (dlen != 2'd0)   nxt = PH_DISP_LO;
                else if (ilen != 2'd0)   nxt = PH_DATA_LO;
                else                     nxt = PH_OPCODE;
            end
            PH_MODRM: begin
                if (dlen != 2'd0)        nxt = PH_DISP_LO;
                else if (ilen != 2'd0)   nxt = PH_DATA_LO;
                else                     nxt = PH_OPCODE;
            end
            PH_DISP_LO: begin
                if (dlen == 2'd2)        nxt = PH_DISP_HI;
                else if (ilen != 2'd0)   nxt = PH_DATA_LO;
                else                     nxt = PH_OPCODE;
            end
            PH_DISP_HI: nxt = (ilen != 2'd0) ? PH_DATA_LO : PH_OPCODE;
            PH_DATA_LO: nxt = (ilen == 2'd2) ? PH_DATA_HI : PH_OPCODE;
            default:    nxt = PH_OPCODE;
        endcase

        rec              = '0;
        rec.kind         = kind;
        rec.displacement = n_disp;
        rec.data         = n_data;
        rec.opcode       = n_opc;
        if (kind <= K_ARI_IMM_A) rec.wide = n_opc[0];
        if (kind == K_MOV_IMM_R) begin
            rec.wide      = n_opc[3];
            rec.reg_field = n_opc[2:0];
        end
        if (kind == K_MOV_RM || kind == K_ARI_RM) rec.to_register = n_opc[1];
        if (kind == K_ARI_RM || kind == K_ARI_IMM_A) rec.operation = op_code(n_opc[5:3]);
        if (kind == K_ARI_IMM_RM) begin
            rec.operation   = op_code(n_modrm[5:3]);
            rec.sign_extend = n_opc[1];
        end
        if (mrm) begin
            rec.reg_field = n_modrm[5:3];
            rec.mode      = n_modrm[7:6];
            rec.rm_field  = n_modrm[2:0];
        end

        n_phase  = r_phase;
        n_halted = r_halted;
        o_emit   = 1'b0;
        if (i_step && !r_halted) begin
            n_phase = nxt;
            o_emit  = (nxt == PH_OPCODE);
            if (r_phase == PH_OPCODE && kind == K_ERROR) n_halted = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_OPCODE;
            r_opc    <= '0;
            r_modrm  <= '0;
            r_disp   <= '0;
            r_data   <= '0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_halted <= n_halted;
            if (i_step && !r_halted) begin
                r_opc   <= n_opc;
                r_modrm <= n_modrm;
                r_disp  <= n_disp;
                r_data  <= n_data;
            end
        end
    end

    assign o_rec              = rec;
    assign o_status.halted    = r_halted;
    assign o_status.at_opcode = (r_phase == PH_OPCODE);

endmodule

// ===== tb/i8086_instruction_decoder_unit_tb.sv =====
// Self-checking testbench for the byte-serial 8086 instruction decoder.
module i8086_instruction_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i86dec_pkg::*;

    // Decoder state mirror plus the queue of records still owed by the block.
    class decode_scoreboard;
        t_phase      ph = PH_OPCODE;
        logic [7:0]  opc = '0;
        logic [7:0]  modrm = '0;
        logic [15:0] disp = '0;
        logic [15:0] imm = '0;
        bit          halted = 1'b0;
        t_rec        expected[$];
        int          bytes_decoded = 0;
        int          bytes_dropped = 0;
        int          records = 0;
        int          mismatches = 0;
        int          kind_seen[16];
        string       diffs;

        function logic [3:0] kind_of(logic [7:0] b);
            logic [3:0] k;
            casez (b)
                8'b100010??: k = K_MOV_RM;
                8'b1011????: k = K_MOV_IMM_R;
                8'b1100011?: k = K_MOV_IMM_RM;
                8'b1010000?: k = K_MEM_ACC;
                8'b1010001?: k = K_ACC_MEM;
                8'b00???0??: k = K_ARI_RM;
                8'b100000??: k = K_ARI_IMM_RM;
                8'b00???10?: k = K_ARI_IMM_A;
                8'b0111????,
                8'b111000??: k = K_JUMP;
                default:     k = K_ERROR;
            endcase
            return k;
        endfunction

        function logic [1:0] op_of(logic [2:0] g);
            case (g)
                GRP_ADD: return OP_ADD;
                GRP_SUB: return OP_SUB;
                GRP_CMP: return OP_CMP;
                default: return OP_UNK;
            endcase
        endfunction

        function bit uses_modrm(logic [3:0] k);
            return k == K_MOV_RM || k == K_MOV_IMM_RM || k == K_ARI_RM || k == K_ARI_IMM_RM;
        endfunction

        function int disp_bytes(logic [3:0] k);
            if (k == K_JUMP) return 1;
            if (!uses_modrm(k)) return 0;
            case (modrm[7:6])
                2'd1: return 1;
                2'd2: return 2;
                2'd0: return (modrm[2:0] == 3'd6) ? 2 : 0;
                default: return 0;
            endcase
        endfunction

        function int imm_bytes(logic [3:0] k);
            case (k)
                K_MOV_IMM_R:               return opc[3] ? 2 : 1;
                K_MOV_IMM_RM, K_ARI_IMM_A: return opc[0] ? 2 : 1;
                K_MEM_ACC, K_ACC_MEM:      return 2;
                K_ARI_IMM_RM:              return (opc[1] || !opc[0]) ? 1 : 2;
                default:                   return 0;
            endcase
        endfunction

        function bit wants(t_phase p, logic [3:0] k);
            case (p)
                PH_MODRM:   return uses_modrm(k);
                PH_DISP_LO: return disp_bytes(k) >= 1;
                PH_DISP_HI: return disp_bytes(k) == 2;
                PH_DATA_LO: return imm_bytes(k) >= 1;
                PH_DATA_HI: return imm_bytes(k) == 2;
                default:    return 1'b0;
            endcase
        endfunction

        function t_phase next_phase(t_phase p, logic [3:0] k);
            t_phase q;
            q = p;
            repeat (6) begin
                case (q)
                    PH_OPCODE:  q = PH_MODRM;
                    PH_MODRM:   q = PH_DISP_LO;
                    PH_DISP_LO: q = PH_DISP_HI;
                    PH_DISP_HI: q = PH_DATA_LO;
                    PH_DATA_LO: q = PH_DATA_HI;
                    default:    q = PH_OPCODE;
                endcase
                if (q == PH_OPCODE || wants(q, k)) return q;
            end
            return PH_OPCODE;
        endfunction

        function t_rec make_record(logic [3:0] k);
            t_rec r;
            r = '0;
            r.kind = k;
            r.displacement = disp;
            r.data = imm;
            r.opcode = opc;
            if (k <= K_ARI_IMM_A) r.wide = opc[0];
            if (k == K_MOV_IMM_R) begin
                r.wide = opc[3];
                r.reg_field = opc[2:0];
            end
            if (k == K_MOV_RM || k == K_ARI_RM) r.to_register = opc[1];
            if (k == K_ARI_RM || k == K_ARI_IMM_A) r.operation = op_of(opc[5:3]);
            if (k == K_ARI_IMM_RM) begin
                r.operation = op_of(modrm[5:3]);
                r.sign_extend = opc[1];
            end
            if (uses_modrm(k)) begin
                r.reg_field = modrm[5:3];
                r.mode = modrm[7:6];
                r.rm_field = modrm[2:0];
            end
            return r;
        endfunction

        function bit at_opcode();
            return ph == PH_OPCODE && !halted;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [3:0] k;
            if (halted) begin
                bytes_dropped++;
                return;
            end
            bytes_decoded++;
            if (ph == PH_OPCODE) begin
                opc = b;
                modrm = '0;
                disp = '0;
                imm = '0;
                k = kind_of(b);
                if (k == K_ERROR) begin
                    expected.push_back(make_record(k));
                    halted = 1'b1;
                    return;
                end
            end else begin
                k = kind_of(opc);
                case (ph)
                    PH_MODRM:   modrm = b;
                    PH_DISP_LO: disp = (disp_bytes(k) == 1) ? {{8{b[7]}}, b} : {8'h00, b};
                    PH_DISP_HI: disp[15:8] = b;
                    // only s=1, w=1 byte immediates get sign-extended
                    PH_DATA_LO: imm = (k == K_ARI_IMM_RM && imm_bytes(k) == 1 && opc[1:0] == 2'b11)
                                      ? {{8{b[7]}}, b} : {8'h00, b};
                    default:    imm[15:8] = b;
                endcase
            end
            ph = next_phase(ph, k);
            if (ph == PH_OPCODE) expected.push_back(make_record(k));
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void cmp(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) diffs = {diffs, $sformatf(" %s exp %0h got %0h", name, want, got)};
        endfunction

        function void check_record(logic [OUT_W-1:0] d);
            t_rec got;
            t_rec want;
            got = d[REC_W-1:0];
            records++;
            if (expected.size() == 0) begin
                report($sformatf("record %0d with nothing pending, opcode %0h",
                                 records, got.opcode));
                return;
            end
            want = expected.pop_front();
            diffs = "";
            cmp("kind", want.kind, got.kind);
            cmp("operation", want.operation, got.operation);
            cmp("to_register", want.to_register, got.to_register);
            cmp("wide", want.wide, got.wide);
            cmp("sign_extend", want.sign_extend, got.sign_extend);
            cmp("reg_field", want.reg_field, got.reg_field);
            cmp("mode", want.mode, got.mode);
            cmp("rm_field", want.rm_field, got.rm_field);
            cmp("displacement", want.displacement, got.displacement);
            cmp("data", want.data, got.data);
            cmp("opcode", want.opcode, got.opcode);
            cmp("pad", '0, d[OUT_W-1:REC_W]);
            if (diffs != "") report($sformatf("record %0d:%s", records, diffs));
            else kind_seen[got.kind]++;
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;   // code_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;        // kind, operation, to_register, wide,
                                               // sign_extend, reg_field, mode, rm_field,
                                               // displacement, data, opcode, zero pad

    decode_scoreboard sb = new();
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int phase_in_pct[4] = '{0, 79, 0, 11};
    int phase_out_pct[4] = '{0, 0, 79, 11};

    // At least one instruction of each form, with field extremes and the zero disp16 case.
    logic [7:0] directed_code [0:29] = '{
        8'h8B, 8'h86, 8'h00, 8'h00,          // mov ax,[bp+0000] via mod 10
        8'hBF, 8'hFF, 8'hFF,                 // mov di,ffff
        8'hA0, 8'h00, 8'h80,                 // mov al,[8000]
        8'hA3, 8'hFF, 8'h7F,                 // mov [7fff],ax
        8'hC6, 8'h06, 8'h34, 8'h12, 8'h00,   // mov byte [1234],00
        8'h83, 8'hC1, 8'h80,                 // add cx,-128 sign-extended
        8'h2A, 8'h47, 8'h80,                 // sub al,[bx-128]
        8'h3C, 8'h7F,                        // cmp al,7f
        8'h08, 8'hC0,                        // or al,al
        8'h75, 8'h80                         // jnz -128
    };

    i8086_instruction_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_record(m_axis_tdata);
        end
    end

    function automatic logic [7:0] pick_opcode();
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(3) == 0) begin
            while (sb.kind_of(b) == K_ERROR) b = 8'($urandom);
            return b;
        end
        // pick a form first so the rare ones come up as often as the common
        case ($urandom_range(8))
            0: b = {6'b100010, b[1:0]};
            1: b = {4'b1011, b[3:0]};
            2: b = {7'b1100011, b[0]};
            3: b = {6'b101000, b[1:0]};
            4: b = {2'b00, b[5:3], 1'b0, b[1:0]};
            5: b = {6'b100000, b[1:0]};
            6: b = {2'b00, b[5:3], 2'b10, b[0]};
            7: b = {4'b0111, b[3:0]};
            default: b = {6'b111000, b[1:0]};
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pick_operand();
        logic [7:0] edge_vals[4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        if ($urandom_range(7) == 0) return edge_vals[$urandom_range(3)];
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
    endtask

    task automatic send_stream(input int count);
        int n;
        n = 0;
        // finish the instruction in flight so the stream ends on a boundary
        while (n < count || !sb.at_opcode()) begin
            send_byte(sb.at_opcode() ? pick_opcode() : pick_operand());
            n++;
        end
    endtask

    // Hold off the sender until every pending record has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.expected.size() != 0);
    endtask

    initial begin
        string per_kind;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_code[i]) send_byte(directed_code[i]);
        drain();

        for (int p = 0; p < 4; p++) begin
            in_idle_pct = phase_in_pct[p];
            out_stall_pct = phase_out_pct[p];
            send_stream(380);
            drain();
        end

        // unknown opcode last: the decoder drops everything after it
        in_idle_pct = 11;
        out_stall_pct = 11;
        send_byte(8'hFF);
        repeat (4) send_byte(8'($urandom));
        drain();
        repeat (20) @(negedge i_clk);

        if (sb.expected.size() != 0)
            sb.report($sformatf("%0d records never arrived", sb.expected.size()));
        per_kind = "";
        for (int k = 0; k <= 9; k++) per_kind = {per_kind, $sformatf(" %0d", sb.kind_seen[k])};
        $display("Decoded %0d code bytes into %0d records under four stall mixes, %0d dropped",
                 sb.bytes_decoded, sb.records, sb.bytes_dropped);
        $display("Records per kind 0..9:%s; mismatches %0d", per_kind, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("[%0t] run timed out", $realtime);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
